### rtl/efdf_pkg.sv
// Package: constants and types for the escaped frame deduplicating filter.
`timescale 1ns / 1ps
package efdf_pkg;

    localparam int unsigned PayloadBytesDef = 16;
    localparam int unsigned RingDepthDef    = 32;
    localparam int unsigned MaxFrameDef     = 64;
    localparam int unsigned PortCountDef    = 2;

    localparam logic [7:0]  EscByte    = 8'hFF;
    localparam logic [7:0]  EscLiteral = 8'h00;
    localparam logic [7:0]  EscClose   = 8'h01;
    localparam logic [31:0] CrcPoly    = 32'hEDB88320;
    localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_SEARCH,
        ST_EMIT,
        ST_WAIT
    } t_state;

    // One bit of the reflected CRC-32 shift.
    function automatic logic [31:0] crc_bit(input logic [31:0] crc);
        crc_bit = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    endfunction

endpackage

### rtl/escaped_frame_dedup_filter.sv
// Top level: per-port deframer, CRC-32 duplicate ring and payload emitter.
//
// Input channel: i_valid/o_stall carry one received byte (i_port, i_data_byte).
// Output channel: o_valid/i_stall carry one payload byte per request with its
// port, last flag, sequence number and frame CRC.
// A payload byte is decoded and then shifted through the shared bit-serial
// CRC shifter; any other byte needs only its decode.
// A closing escape with the right length walks the CRC ring one entry a cycle,
// dropping the frame on a match; otherwise it emits PAYLOAD_BYTES requests, one
// per cycle that the receiver does not stall, reading the payload memory ahead
// through a registered read port.
// The block holds o_stall high while it works on an item; a stalled output
// holds its request unchanged.
// Reset clears the deframers, the ring (through per-entry valid bits, so no
// clearing pass is needed), the ring slot and the unique frame count.
module escaped_frame_dedup_filter
    import efdf_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PayloadBytesDef,
    parameter int unsigned RING_DEPTH    = RingDepthDef,
    parameter int unsigned MAX_FRAME     = MaxFrameDef,
    parameter int unsigned PORT_COUNT    = PortCountDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [0:0]  i_port,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [0:0]  o_source_port,
    output logic [7:0]  o_payload_byte,
    output logic        o_is_last,
    output logic [31:0] o_frame_sequence,
    output logic [31:0] o_frame_crc
);

    localparam int unsigned PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int unsigned BW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int unsigned RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned FW = $clog2(MAX_FRAME + 1);
    localparam int unsigned MD = PORT_COUNT * PAYLOAD_BYTES;
    localparam int unsigned MW = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [FW-1:0] MaxPos  = FW'(MAX_FRAME);
    localparam logic [FW-1:0] FullPos = FW'(PAYLOAD_BYTES + 1);
    localparam logic [BW-1:0] LastIdx = BW'(PAYLOAD_BYTES - 1);
    localparam logic [RW-1:0] LastSlot = RW'(RING_DEPTH - 1);

    // Per-port deframer state
    logic [PORT_COUNT-1:0] r_esc;
    logic [FW-1:0]         r_pos [PORT_COUNT];
    logic [31:0]           r_crc [PORT_COUNT];

    // Shared state
    logic [7:0]            r_mem [MD];
    logic [31:0]           r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [RW-1:0]         r_slot;
    logic [31:0]           r_count;

    // Sequencer
    t_state        r_state, n_state;
    logic [PW-1:0] r_p;
    logic [31:0]   r_work;
    logic [2:0]    r_bit;
    logic [RW-1:0] r_idx;
    logic          r_dup;
    logic [BW-1:0] r_rd;
    logic [7:0]    r_rdata;
    logic          r_rvld;
    logic          r_rlast;
    logic          r_rdone;
    logic [31:0]   r_fcrc;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;

    logic          in_acc, out_acc;
    logic [PW-1:0] in_p;
    logic          port_ok;
    logic          ring_hit;
    logic [31:0]   ring_val;
    logic          emit_load;
    logic          emit_fetch;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign in_p    = PW'(i_port);
    assign port_ok = (32'(i_port) < PORT_COUNT);
    assign o_stall = (r_state != ST_IDLE);
    assign ring_val = r_ring_vld[r_idx] ? r_ring[r_idx] : 32'h0;
    assign ring_hit = (ring_val == r_fcrc);

    // Load the output register from the read register when it is free or being taken,
    // and fetch the next byte until the last whenever the read register is empty or drained
    assign emit_load  = (r_state == ST_EMIT) && r_rvld && (!r_ovalid || out_acc);
    assign emit_fetch = (r_state == ST_EMIT) && !r_rdone && (!r_rvld || emit_load);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && port_ok) begin
                    if (r_esc[in_p] && i_data_byte == EscClose
                            && r_pos[in_p] == FullPos) begin
                        n_state = ST_SEARCH;
                    end else if (((r_esc[in_p] && i_data_byte == EscLiteral)
                            || (!r_esc[in_p] && i_data_byte != EscByte))
                            && r_pos[in_p] >= FW'(1) && r_pos[in_p] <= FW'(PAYLOAD_BYTES)) begin
                        n_state = ST_CRC;
                    end
                end
            end
            ST_CRC:    if (r_bit == 3'd7) n_state = ST_IDLE;
            ST_SEARCH: begin
                if (ring_hit) n_state = ST_IDLE;
                else if (r_idx == LastSlot) n_state = ST_EMIT;
            end
            ST_EMIT:   if (out_acc && r_olast) n_state = ST_WAIT;
            ST_WAIT:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Deframer, CRC shifter, ring and emitter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= '0;
            r_ring_vld <= '0;
            r_slot     <= '0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_rvld     <= 1'b0;
            for (int k = 0; k < PORT_COUNT; k++) begin
                r_pos[k] <= '0;
                r_crc[k] <= CrcInit;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_bit   <= '0;
                    r_idx   <= '0;
                    r_rd    <= '0;
                    r_rdone <= 1'b0;
                    if (in_acc && port_ok) begin
                        r_p <= in_p;
                        if (r_esc[in_p]) begin
                            r_esc[in_p] <= 1'b0;
                            if (i_data_byte == EscLiteral) begin
                                if (r_pos[in_p] < MaxPos) begin
                                    r_pos[in_p] <= r_pos[in_p] + FW'(1);
                                    if (r_pos[in_p] >= FW'(1)
                                            && r_pos[in_p] <= FW'(PAYLOAD_BYTES)) begin
                                        r_mem[MW'(32'(in_p) * PAYLOAD_BYTES
                                            + 32'(r_pos[in_p]) - 1)] <= EscByte;
                                        r_work <= r_crc[in_p] ^ 32'(EscByte);
                                    end
                                end
                            end else if (i_data_byte == EscClose) begin
                                r_fcrc      <= ~r_crc[in_p];
                                r_pos[in_p] <= '0;
                                r_crc[in_p] <= CrcInit;
                            end
                        end else if (i_data_byte == EscByte) begin
                            r_esc[in_p] <= 1'b1;
                        end else if (r_pos[in_p] < MaxPos) begin
                            r_pos[in_p] <= r_pos[in_p] + FW'(1);
                            if (r_pos[in_p] >= FW'(1) && r_pos[in_p] <= FW'(PAYLOAD_BYTES)) begin
                                r_mem[MW'(32'(in_p) * PAYLOAD_BYTES
                                    + 32'(r_pos[in_p]) - 1)] <= i_data_byte;
                                r_work <= r_crc[in_p] ^ 32'(i_data_byte);
                            end
                        end
                    end
                end
                ST_CRC: begin
                    // Advance one bit per cycle through the shared shifter
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) r_crc[r_p] <= crc_bit(r_work);
                    else               r_work     <= crc_bit(r_work);
                end
                ST_SEARCH: begin
                    r_idx <= r_idx + RW'(1);
                    if (!ring_hit && r_idx == LastSlot) begin
                        r_ring[r_slot]     <= r_fcrc;
                        r_ring_vld[r_slot] <= 1'b1;
                        r_slot <= (r_slot == LastSlot) ? '0 : r_slot + RW'(1);
                    end
                end
                ST_EMIT: begin
                    // Prefetch from memory into the read register
                    if (emit_fetch) begin
                        r_rdata <= r_mem[MW'(32'(r_p) * PAYLOAD_BYTES + 32'(r_rd))];
                        r_rlast <= (r_rd == LastIdx);
                        r_rdone <= (r_rd == LastIdx);
                        r_rvld  <= 1'b1;
                        r_rd    <= r_rd + BW'(1);
                    end else if (emit_load) begin
                        r_rvld  <= 1'b0;
                    end
                    // Move into the output register when it is free or being taken; else drop it once taken
                    if (emit_load) begin
                        r_obyte  <= r_rdata;
                        r_olast  <= r_rlast;
                        r_ovalid <= 1'b1;
                    end else if (out_acc) begin
                        r_ovalid <= 1'b0;
                    end
                    if (out_acc && r_olast) r_count <= r_count + 32'd1;
                end
                ST_WAIT: r_rvld <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_source_port    = 1'(r_p);
    assign o_payload_byte   = r_obyte;
    assign o_is_last        = r_olast;
    assign o_frame_sequence = r_count;
    assign o_frame_crc      = r_fcrc;

`ifndef SYNTHESIS
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EMIT) |-> !r_ovalid) else $error("output outside emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_obyte)))
        else $error("stalled request changed");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_olast) |=> (r_count == $past(r_count) + 32'd1))
        else $error("count not advanced");
`endif

endmodule

### sim/escaped_frame_dedup_filter_tb.sv
// Testbench: escaped frame deframer with CRC-32 duplicate filter, checked by a predictor.
`timescale 1ns / 1ps
module escaped_frame_dedup_filter_tb;
    import efdf_pkg::*;

    localparam int PAYLOAD = 16;
    localparam int RING    = 32;
    localparam int MAXLEN  = 64;

    typedef struct packed {
        logic [0:0]  port;
        logic [7:0]  data;
        logic        last;
        logic [31:0] seq;
        logic [31:0] crc;
    } t_payload_out;

    typedef struct {
        bit       port;
        bit [7:0] data;
        bit       no_output;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [0:0]  i_port;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [0:0]  o_source_port;
    logic [7:0]  o_payload_byte;
    logic        o_is_last;
    logic [31:0] o_frame_sequence;
    logic [31:0] o_frame_crc;

    escaped_frame_dedup_filter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_port(i_port), .i_data_byte(i_data_byte), .o_valid(o_valid), .i_stall(i_stall),
        .o_source_port(o_source_port), .o_payload_byte(o_payload_byte),
        .o_is_last(o_is_last), .o_frame_sequence(o_frame_sequence),
        .o_frame_crc(o_frame_crc)
    );

    // Predictor state
    bit          esc_open [2];
    int unsigned frame_pos [2];
    bit [7:0]    frame_bytes [2][PAYLOAD];
    bit [31:0]   crc_acc [2];
    bit [31:0]   crc_ring [RING];
    int unsigned ring_slot;
    bit [31:0]   unique_frames;

    t_payload_out payload_q[$];
    int errors;
    int bytes_sent;
    int bytes_seen;
    int frames_dropped;
    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold_req;
    int hold_left;

    // Hold the clock running
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    function automatic bit [31:0] crc_byte(bit [31:0] c, bit [7:0] b);
        c ^= {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    // Four trailing bytes that steer the CRC register from state s to state t
    function automatic bit [31:0] crc_steer(bit [31:0] s, bit [31:0] t);
        bit [31:0] r;
        r = t;
        for (int k = 0; k < 32; k++)
            r = r[31] ? (((r ^ 32'hEDB88320) << 1) | 32'd1) : (r << 1);
        return s ^ r;
    endfunction

    function automatic void frame_push(bit p, bit [7:0] b);
        if (frame_pos[p] >= MAXLEN)
            return;
        if (frame_pos[p] >= 1 && frame_pos[p] <= PAYLOAD) begin
            frame_bytes[p][frame_pos[p] - 1] = b;
            crc_acc[p] = crc_byte(crc_acc[p], b);
        end
        frame_pos[p]++;
    endfunction

    // Advance the deframer of one port and queue any payload it releases
    function automatic int predict_byte(bit p, bit [7:0] b);
        bit [31:0] c;
        bit dup;
        t_payload_out r;
        int n;
        n = 0;
        if (esc_open[p]) begin
            esc_open[p] = 1'b0;
            if (b == EscLiteral) begin
                frame_push(p, EscByte);
            end else if (b == EscClose) begin
                if (frame_pos[p] == PAYLOAD + 1) begin
                    c = ~crc_acc[p];
                    dup = 1'b0;
                    foreach (crc_ring[i])
                        if (crc_ring[i] == c)
                            dup = 1'b1;
                    if (dup) begin
                        frames_dropped++;
                    end else begin
                        crc_ring[ring_slot] = c;
                        ring_slot = (ring_slot + 1) % RING;
                        for (int i = 0; i < PAYLOAD; i++) begin
                            r.port = p;
                            r.data = frame_bytes[p][i];
                            r.last = (i == PAYLOAD - 1);
                            r.seq  = unique_frames;
                            r.crc  = c;
                            payload_q.push_back(r);
                        end
                        n = PAYLOAD;
                        unique_frames++;
                    end
                end
                frame_pos[p] = 0;
                crc_acc[p] = 32'hFFFFFFFF;
            end
        end else if (b == EscByte) begin
            esc_open[p] = 1'b1;
        end else begin
            frame_push(p, b);
        end
        return n;
    endfunction

    // Offer one request, idling first at the phase's rate; valid stays high afterwards
    task automatic send_byte(bit p, bit [7:0] b, output int n);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_port      <= p;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        n = predict_byte(p, b);
        bytes_sent++;
    endtask

    // Escape-code a frame: its bytes with each 0xFF escaped, then a closing escape if asked
    function automatic void encode_frame(ref bit [7:0] q[$], input bit [7:0] pl[], bit close);
        foreach (pl[i]) begin
            q.push_back(pl[i]);
            if (pl[i] == EscByte)
                q.push_back(EscLiteral);
        end
        if (close) begin
            q.push_back(EscByte);
            q.push_back(EscClose);
        end
    endfunction

    task automatic send_stream(bit p, bit [7:0] q[$]);
        int n;
        foreach (q[i])
            send_byte(p, q[i], n);
    endtask

    // Receive and check; stall at the phase's rate or through a long hold
    always @(posedge i_clk) begin
        t_payload_out e;
        if (o_valid && !i_stall && i_rst_n) begin
            bytes_seen++;
            if (payload_q.size() == 0) begin
                $error("unexpected output byte %0h", o_payload_byte);
                errors++;
            end else begin
                e = payload_q.pop_front();
                if (o_source_port !== e.port) begin
                    $error("source_port exp %0h got %0h", e.port, o_source_port);
                    errors++;
                end
                if (o_payload_byte !== e.data) begin
                    $error("payload_byte exp %0h got %0h", e.data, o_payload_byte);
                    errors++;
                end
                if (o_is_last !== e.last) begin
                    $error("is_last exp %0h got %0h", e.last, o_is_last);
                    errors++;
                end
                if (o_frame_sequence !== e.seq) begin
                    $error("frame_sequence exp %0h got %0h", e.seq, o_frame_sequence);
                    errors++;
                end
                if (o_frame_crc !== e.crc) begin
                    $error("frame_crc exp %0h got %0h", e.crc, o_frame_crc);
                    errors++;
                end
            end
        end
        if (long_hold_req && hold_left == 0) begin
            long_hold_req = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    t_stim_row short_rows[] = '{
        '{0, 8'hFF, 1}, '{0, 8'h01, 1},              // close of an empty frame
        '{1, 8'h00, 1}, '{1, 8'hFF, 1}, '{1, 8'h7E, 1}, // unknown escape dropped
        '{1, 8'hFF, 1}, '{1, 8'h01, 1},              // wrong length close
        '{0, 8'h55, 1}, '{0, 8'hFF, 1}, '{0, 8'h02, 1},
        '{0, 8'hFF, 1}, '{0, 8'h01, 1}
    };

    initial begin
        bit [7:0] q[$];
        bit [7:0] q1[$];
        bit [7:0] pl[];
        bit [7:0] last_pl[];
        bit [31:0] c;
        bit [31:0] steer;
        int n;
        int len;
        bit p;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_port = '0;
        i_data_byte = '0;
        i_stall = 1'b0;
        errors = 0;
        bytes_sent = 0;
        bytes_seen = 0;
        frames_dropped = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_req = 1'b0;
        hold_left = 0;
        for (int i = 0; i < 2; i++) begin
            esc_open[i] = 1'b0;
            frame_pos[i] = 0;
            crc_acc[i] = 32'hFFFFFFFF;
        end
        foreach (crc_ring[i])
            crc_ring[i] = '0;
        ring_slot = 0;
        unique_frames = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short error sequences, none of which may release payload
        foreach (short_rows[i]) begin
            send_byte(short_rows[i].port, short_rows[i].data, n);
            if (short_rows[i].no_output && n != 0) begin
                $error("row %0d released %0d bytes, expected none", i, n);
                errors++;
            end
        end

        // Payload whose CRC is zero: a duplicate of the zeroed ring
        pl = new[17];
        c = 32'hFFFFFFFF;
        for (int i = 1; i < 13; i++) begin
            pl[i] = 8'($urandom_range(255));
            c = crc_byte(c, pl[i]);
        end
        steer = crc_steer(c, 32'hFFFFFFFF);
        for (int i = 0; i < 4; i++)
            pl[13 + i] = steer[8 * i +: 8];
        q = {};
        encode_frame(q, pl, 1);
        send_stream(1, q);

        // Extremes: all 0xFF, all 0x00, then a repeat that must be dropped
        pl = new[17];
        foreach (pl[i]) pl[i] = 8'hFF;
        q = {};
        encode_frame(q, pl, 1);
        send_stream(0, q);
        foreach (pl[i]) pl[i] = 8'h00;
        q = {};
        encode_frame(q, pl, 1);
        send_stream(1, q);
        send_stream(0, q);

        // Overflow: 70 bytes then close
        pl = new[70];
        foreach (pl[i]) pl[i] = 8'($urandom_range(254));
        q = {};
        encode_frame(q, pl, 1);
        send_stream(0, q);
        last_pl = pl;

        // Random phases: no idling but a long receiver hold, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 12 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 12 : 0;
            if (ph == 0)
                long_hold_req = 1'b1;
            q = {};
            q1 = {};
            while (q.size() + q1.size() < 20) begin
                p = 1'($urandom_range(1));
                n = $urandom_range(99);
                if (n < 70) begin
                    pl = new[17];
                    foreach (pl[i])
                        pl[i] = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255));
                end else if (n < 80 && last_pl.size() == 17) begin
                    pl = last_pl;
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(66, 70) : $urandom_range(0, 20);
                    pl = new[len];
                    foreach (pl[i]) pl[i] = 8'($urandom_range(255));
                end
                last_pl = pl;
                if (p)
                    encode_frame(q1, pl, $urandom_range(9) != 0);
                else
                    encode_frame(q, pl, $urandom_range(9) != 0);
                if ($urandom_range(9) == 0) begin
                    if (p) q1.push_back(EscByte); else q.push_back(EscByte);
                end
            end
            // Interleave the two ports byte by byte
            while (q.size() + q1.size() > 0) begin
                p = (q.size() == 0) ? 1'b1 : (q1.size() == 0) ? 1'b0 : 1'($urandom_range(1));
                if (p)
                    send_byte(1, q1.pop_front(), n);
                else
                    send_byte(0, q.pop_front(), n);
            end
        end

        i_valid <= 1'b0;
        while (payload_q.size() != 0 || hold_left != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d bytes on two ports; %0d unique frames, %0d payload bytes checked,",
                 bytes_sent, unique_frames, bytes_seen);
        $display("%0d duplicates dropped, with idle, stall and long hold phases.",
                 frames_dropped);
        if (errors == 0 && payload_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
